[rtl/mm_pkg.sv]
`timescale 1ns / 1ps

package mm_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 35;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Item modes
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Register indexes (word offsets)
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_COLS_N  = 2'd1;
  localparam logic [1:0] REG_INNER_L = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Configured matrix sizes, already clamped to 1..MAX_DIM
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] inner;
  } dims_t;

  // Controller to datapath
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             issue;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             first;
    logic             lastk;
    logic             last_entry;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic adv;
    logic busy;
  } status_t;

  // Tag that travels with each product through the pipeline
  typedef struct packed {
    logic             first;
    logic             lastk;
    logic             last_entry;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } tag_t;

endpackage

[rtl/mm_cfg_regs.sv]
`timescale 1ns / 1ps

module mm_cfg_regs
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output dims_t             dims
);

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  dims_t            dims_r, dims_nxt;
  logic             wr_en;
  logic [DIM_W-1:0] wr_val;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Clamp written value into 1..MAX_DIM
  always_comb begin
    if (pwdata == '0) begin
      wr_val = DIM_W'(1);
    end else if (pwdata > DATA_W'(MAX_DIM)) begin
      wr_val = DIM_MAX;
    end else begin
      wr_val = pwdata[DIM_W-1:0];
    end
  end

  // Register write decode
  always_comb begin
    dims_nxt = dims_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ROWS_M:  dims_nxt.rows  = wr_val;
        REG_COLS_N:  dims_nxt.cols  = wr_val;
        REG_INNER_L: dims_nxt.inner = wr_val;
        default:     dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= '{rows: DIM_MAX, cols: DIM_MAX, inner: DIM_MAX};
    end else begin
      dims_r <= dims_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_ROWS_M:  prdata = DATA_W'(dims_r.rows);
      REG_COLS_N:  prdata = DATA_W'(dims_r.cols);
      REG_INNER_L: prdata = DATA_W'(dims_r.inner);
      default:     prdata = '0;
    endcase
  end

  assign dims = dims_r;

endmodule

[rtl/mm_ctrl.sv]
`timescale 1ns / 1ps

module mm_ctrl
  import mm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  dims_t      dims,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             lastk, lastj, lasti;

  // End-of-loop flags for the three nested counters
  assign lastk = ({1'b0, k_r} == dims.inner - DIM_W'(1));
  assign lastj = ({1'b0, j_r} == dims.cols - DIM_W'(1));
  assign lasti = ({1'b0, i_r} == dims.rows - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state, counters and commands
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    in_stall       = 1'b1;
    cmd.load_a     = 1'b0;
    cmd.load_b     = 1'b0;
    cmd.issue      = 1'b0;
    cmd.i          = i_r;
    cmd.j          = j_r;
    cmd.k          = k_r;
    cmd.first      = (k_r == '0);
    cmd.lastk      = lastk;
    cmd.last_entry = lasti && lastj;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD_A: cmd.load_a = 1'b1;
            MODE_LOAD_B: cmd.load_b = 1'b1;
            MODE_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.adv) begin
          if (!lastk) begin
            k_nxt = k_r + IDX_W'(1);
          end else begin
            k_nxt = '0;
            if (!lastj) begin
              j_nxt = j_r + IDX_W'(1);
            end else begin
              j_nxt = '0;
              if (!lasti) begin
                i_nxt = i_r + IDX_W'(1);
              end else begin
                state_nxt = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/mm_datapath.sv]
`timescale 1ns / 1ps

module mm_datapath
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] out_product_sum,
  output logic                    out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W = 2 * IDX_W + 1;

  logic signed [VAL_W-1:0] a_mem [DEPTH];
  logic signed [VAL_W-1:0] b_mem [DEPTH];

  logic [LIN_W-1:0]         wr_lin, a_lin, b_lin;
  logic [AW-1:0]            wr_addr, a_addr, b_addr;
  logic                     wr_in_range;
  logic                     adv, rd_en, out_load;

  logic signed [VAL_W-1:0]  a_q_r, b_q_r;
  logic                     s1_v_r, s2_v_r;
  tag_t                     s1_tag_r, s2_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic                     out_last_r;

  // Whole pipeline freezes while a finished result is held off
  assign adv         = !(out_valid_r && out_stall);
  assign rd_en       = cmd.issue && adv;
  assign status.adv  = adv;
  assign status.busy = s1_v_r || s2_v_r || out_valid_r;

  // Linear addresses: row * MAX_DIM + col
  assign wr_lin  = LIN_W'(in_row) * LIN_W'(MAX_DIM) + LIN_W'(in_col);
  assign a_lin   = LIN_W'(cmd.i) * LIN_W'(MAX_DIM) + LIN_W'(cmd.k);
  assign b_lin   = LIN_W'(cmd.k) * LIN_W'(MAX_DIM) + LIN_W'(cmd.j);
  assign wr_addr = wr_lin[AW-1:0];
  assign a_addr  = a_lin[AW-1:0];
  assign b_addr  = b_lin[AW-1:0];

  // Loads beyond the store bounds are dropped
  assign wr_in_range = ({1'b0, in_row} < (IDX_W + 1)'(MAX_DIM)) &&
                       ({1'b0, in_col} < (IDX_W + 1)'(MAX_DIM));

  // Element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.load_a && wr_in_range) begin
      a_mem[wr_addr] <= in_value;
    end
    if (cmd.load_b && wr_in_range) begin
      b_mem[wr_addr] <= in_value;
    end
    if (rd_en) begin
      a_q_r <= a_mem[a_addr];
      b_q_r <= b_mem[b_addr];
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  // Tags, product and accumulator
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r <= '{first: cmd.first, lastk: cmd.lastk, last_entry: cmd.last_entry,
                    i: cmd.i, j: cmd.j};
      s2_tag_r <= s1_tag_r;
      prod_r   <= a_q_r * b_q_r;
      if (s2_v_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign acc_nxt = (s2_tag_r.first ? '0 : acc_r) + SUM_W'(prod_r);
  assign out_load = adv && s2_v_r && s2_tag_r.lastk;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= s2_tag_r.i;
      out_col_r  <= s2_tag_r.j;
      out_sum_r  <= acc_nxt;
      out_last_r <= s2_tag_r.last_entry;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_product_sum = out_sum_r;
  assign out_last        = out_last_r;

endmodule

[rtl/matrix_multiply_top.sv]
// Matrix multiply C = A x B over on-chip A and B stores.
// Load transactions are accepted back to back while the block is idle.
// A compute transaction holds the input until every result has drained; the
// store read ports give one product per cycle while the output is not stalled.
// The first result passes the store read, product and output registers in turn.
// Synchronous active-low reset clears control and sets all sizes to MAX_DIM.
`timescale 1ns / 1ps

module matrix_multiply_top
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_mode,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] out_product_sum,
  output logic                    out_last,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  dims_t   dims;
  cmd_t    cmd;
  status_t status;

  mm_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  mm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .dims     (dims),
    .status   (status),
    .cmd      (cmd)
  );

  mm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_product_sum (out_product_sum),
    .out_last        (out_last)
  );

  // No result may be pending while input transactions are taken
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result pending while input open");

  // A compute transaction closes the input
  a_compute_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode == MODE_COMPUTE |=> in_stall)
    else $error("input not held after compute");

  // Input reopens once the final entry is taken and the controller returns to idle
  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_stall |-> ##2 !in_stall)
    else $error("input not reopened after final entry");

endmodule
